[rtl/core/mid_pkg.sv]
// ----------------------------------------------------------------------------
// mid_pkg: shared types and codes for the instruction decoder
// Opcode, funct, mnemonic and operand format codes and field widths.
// ----------------------------------------------------------------------------
package mid_pkg;

    localparam int WORD_W  = 32;
    localparam int INDEX_W = 30;
    localparam int REG_W   = 5;
    localparam int OPC_W   = 6;
    localparam int IMM_W   = 16;
    localparam int IMMX_W  = 17;
    localparam int ID_W    = 5;
    localparam int FMT_W   = 3;

    // opcodes
    localparam logic [OPC_W-1:0] OPC_RTYPE = 6'd0;
    localparam logic [OPC_W-1:0] OPC_BEQ   = 6'd4;
    localparam logic [OPC_W-1:0] OPC_BNE   = 6'd5;
    localparam logic [OPC_W-1:0] OPC_ADDI  = 6'd8;
    localparam logic [OPC_W-1:0] OPC_ADDIU = 6'd9;
    localparam logic [OPC_W-1:0] OPC_SLTI  = 6'd10;
    localparam logic [OPC_W-1:0] OPC_SLTIU = 6'd11;
    localparam logic [OPC_W-1:0] OPC_ANDI  = 6'd12;
    localparam logic [OPC_W-1:0] OPC_ORI   = 6'd13;
    localparam logic [OPC_W-1:0] OPC_LUI   = 6'd15;
    localparam logic [OPC_W-1:0] OPC_LW    = 6'd35;
    localparam logic [OPC_W-1:0] OPC_LBU   = 6'd36;
    localparam logic [OPC_W-1:0] OPC_LHU   = 6'd37;
    localparam logic [OPC_W-1:0] OPC_SB    = 6'd40;
    localparam logic [OPC_W-1:0] OPC_SH    = 6'd41;
    localparam logic [OPC_W-1:0] OPC_SW    = 6'd43;
    localparam logic [OPC_W-1:0] OPC_LL    = 6'd48;
    localparam logic [OPC_W-1:0] OPC_SC    = 6'd56;

    // R-type funct codes
    localparam logic [OPC_W-1:0] FN_SLL  = 6'd0;
    localparam logic [OPC_W-1:0] FN_SRL  = 6'd2;
    localparam logic [OPC_W-1:0] FN_ADD  = 6'd32;
    localparam logic [OPC_W-1:0] FN_ADDU = 6'd33;
    localparam logic [OPC_W-1:0] FN_SUB  = 6'd34;
    localparam logic [OPC_W-1:0] FN_SUBU = 6'd35;
    localparam logic [OPC_W-1:0] FN_AND  = 6'd36;
    localparam logic [OPC_W-1:0] FN_OR   = 6'd37;
    localparam logic [OPC_W-1:0] FN_NOR  = 6'd39;
    localparam logic [OPC_W-1:0] FN_SLT  = 6'd42;
    localparam logic [OPC_W-1:0] FN_SLTU = 6'd43;

    // mnemonic ids
    localparam logic [ID_W-1:0] ID_SLL   = 5'd0;
    localparam logic [ID_W-1:0] ID_SRL   = 5'd1;
    localparam logic [ID_W-1:0] ID_ADD   = 5'd2;
    localparam logic [ID_W-1:0] ID_ADDU  = 5'd3;
    localparam logic [ID_W-1:0] ID_SUB   = 5'd4;
    localparam logic [ID_W-1:0] ID_SUBU  = 5'd5;
    localparam logic [ID_W-1:0] ID_AND   = 5'd6;
    localparam logic [ID_W-1:0] ID_OR    = 5'd7;
    localparam logic [ID_W-1:0] ID_NOR   = 5'd8;
    localparam logic [ID_W-1:0] ID_SLT   = 5'd9;
    localparam logic [ID_W-1:0] ID_SLTU  = 5'd10;
    localparam logic [ID_W-1:0] ID_BEQ   = 5'd11;
    localparam logic [ID_W-1:0] ID_BNE   = 5'd12;
    localparam logic [ID_W-1:0] ID_ADDI  = 5'd13;
    localparam logic [ID_W-1:0] ID_ADDIU = 5'd14;
    localparam logic [ID_W-1:0] ID_ANDI  = 5'd15;
    localparam logic [ID_W-1:0] ID_LBU   = 5'd16;
    localparam logic [ID_W-1:0] ID_LHU   = 5'd17;
    localparam logic [ID_W-1:0] ID_LL    = 5'd18;
    localparam logic [ID_W-1:0] ID_LUI   = 5'd19;
    localparam logic [ID_W-1:0] ID_LW    = 5'd20;
    localparam logic [ID_W-1:0] ID_ORI   = 5'd21;
    localparam logic [ID_W-1:0] ID_SLTI  = 5'd22;
    localparam logic [ID_W-1:0] ID_SLTIU = 5'd23;
    localparam logic [ID_W-1:0] ID_SB    = 5'd24;
    localparam logic [ID_W-1:0] ID_SH    = 5'd25;
    localparam logic [ID_W-1:0] ID_SW    = 5'd26;
    localparam logic [ID_W-1:0] ID_SC    = 5'd27;

    // operand formats
    localparam logic [FMT_W-1:0] FMT_SHIFT = 3'd0;
    localparam logic [FMT_W-1:0] FMT_RRR   = 3'd1;
    localparam logic [FMT_W-1:0] FMT_BR    = 3'd2;
    localparam logic [FMT_W-1:0] FMT_RRI   = 3'd3;
    localparam logic [FMT_W-1:0] FMT_MEM   = 3'd4;
    localparam logic [FMT_W-1:0] FMT_RI    = 3'd5;

    // registers from here up have no name
    localparam logic [REG_W-1:0] FIRST_BAD_REG = 5'd26;

    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [FMT_W-1:0] fmt;
    } op_info_t;

endpackage

[rtl/core/mid_op_lookup.sv]
// ----------------------------------------------------------------------------
// mid_op_lookup: opcode / funct decode
// Maps opcode and funct to valid flag, mnemonic id and operand format.
// ----------------------------------------------------------------------------
module mid_op_lookup (
    input  logic [mid_pkg::OPC_W-1:0] opcode,
    input  logic [mid_pkg::OPC_W-1:0] funct,
    output mid_pkg::op_info_t         info
);
    import mid_pkg::*;

    always_comb
    begin
        info = '0;
        if (opcode == OPC_RTYPE)
        begin
            case (funct)
                FN_SLL:  info = '{1'b1, ID_SLL,  FMT_SHIFT};
                FN_SRL:  info = '{1'b1, ID_SRL,  FMT_SHIFT};
                FN_ADD:  info = '{1'b1, ID_ADD,  FMT_RRR};
                FN_ADDU: info = '{1'b1, ID_ADDU, FMT_RRR};
                FN_SUB:  info = '{1'b1, ID_SUB,  FMT_RRR};
                FN_SUBU: info = '{1'b1, ID_SUBU, FMT_RRR};
                FN_AND:  info = '{1'b1, ID_AND,  FMT_RRR};
                FN_OR:   info = '{1'b1, ID_OR,   FMT_RRR};
                FN_NOR:  info = '{1'b1, ID_NOR,  FMT_RRR};
                FN_SLT:  info = '{1'b1, ID_SLT,  FMT_RRR};
                FN_SLTU: info = '{1'b1, ID_SLTU, FMT_RRR};
                default: info = '0;
            endcase
        end
        else
        begin
            case (opcode)
                OPC_BEQ:   info = '{1'b1, ID_BEQ,   FMT_BR};
                OPC_BNE:   info = '{1'b1, ID_BNE,   FMT_BR};
                OPC_ADDI:  info = '{1'b1, ID_ADDI,  FMT_RRI};
                OPC_ADDIU: info = '{1'b1, ID_ADDIU, FMT_RRI};
                OPC_ANDI:  info = '{1'b1, ID_ANDI,  FMT_RRI};
                OPC_LBU:   info = '{1'b1, ID_LBU,   FMT_MEM};
                OPC_LHU:   info = '{1'b1, ID_LHU,   FMT_MEM};
                OPC_LL:    info = '{1'b1, ID_LL,    FMT_MEM};
                OPC_LUI:   info = '{1'b1, ID_LUI,   FMT_RI};
                OPC_LW:    info = '{1'b1, ID_LW,    FMT_MEM};
                OPC_ORI:   info = '{1'b1, ID_ORI,   FMT_RRI};
                OPC_SLTI:  info = '{1'b1, ID_SLTI,  FMT_RRI};
                OPC_SLTIU: info = '{1'b1, ID_SLTIU, FMT_RRI};
                OPC_SB:    info = '{1'b1, ID_SB,    FMT_MEM};
                OPC_SH:    info = '{1'b1, ID_SH,    FMT_MEM};
                OPC_SW:    info = '{1'b1, ID_SW,    FMT_MEM};
                OPC_SC:    info = '{1'b1, ID_SC,    FMT_MEM};
                default:   info = '0;
            endcase
        end
    end

endmodule

[rtl/core/mid_target_calc.sv]
// ----------------------------------------------------------------------------
// mid_target_calc: branch target address
// Byte address (index + 1 + imm) * 4, wrapping at 32 bits; zero if no branch.
// ----------------------------------------------------------------------------
module mid_target_calc (
    input  logic [mid_pkg::INDEX_W-1:0] word_index,
    input  logic [mid_pkg::IMM_W-1:0]   imm,
    input  logic                        is_branch,
    output logic [mid_pkg::WORD_W-1:0]  target
);
    import mid_pkg::*;

    logic [INDEX_W-1:0] imm_ext;
    logic [INDEX_W-1:0] word_sum;

    // only the low 30 bits of the word sum survive the * 4
    assign imm_ext  = {{(INDEX_W-IMM_W){imm[IMM_W-1]}}, imm};
    assign word_sum = word_index + imm_ext + INDEX_W'(1);
    assign target   = is_branch ? {word_sum, 2'b00} : '0;

endmodule

[rtl/core/mips_instruction_decoder.sv]
// ----------------------------------------------------------------------------
// mips_instruction_decoder: MIPS32 instruction word decoder
// Decodes one instruction word per cycle into mnemonic, format, fields,
// immediate, branch target and an unnamed-register flag.
// ----------------------------------------------------------------------------
//  channel | direction | handshake    | payload
//  --------+-----------+--------------+---------------------------------------
//  command | in        | start / busy | instr_word, word_index
//  result  | out       | done         | known_op, mnemonic_id, operand_format,
//          |           |              | dest_reg, src_reg, second_reg,
//          |           |              | shift_amount, immediate_value,
//          |           |              | branch_target, reg_name_unknown
//
//  An item accepted at the input register shows its result with done once it
//  has passed the result register (stages: input register, result register).
//  One item per cycle sustained; busy is always low.
//  Reset clears the valid flags of both stages; nothing else is reset.
//  The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module mips_instruction_decoder (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [mid_pkg::WORD_W-1:0]          instr_word,
    input  logic [mid_pkg::INDEX_W-1:0]         word_index,
    output logic                                done,
    output logic                                known_op,
    output logic [mid_pkg::ID_W-1:0]            mnemonic_id,
    output logic [mid_pkg::FMT_W-1:0]           operand_format,
    output logic [mid_pkg::REG_W-1:0]           dest_reg,
    output logic [mid_pkg::REG_W-1:0]           src_reg,
    output logic [mid_pkg::REG_W-1:0]           second_reg,
    output logic [mid_pkg::REG_W-1:0]           shift_amount,
    output logic signed [mid_pkg::IMMX_W-1:0]   immediate_value,
    output logic [mid_pkg::WORD_W-1:0]          branch_target,
    output logic                                reg_name_unknown
);
    import mid_pkg::*;

    // input stage
    logic               in_valid_reg;
    logic [WORD_W-1:0]  word_reg;
    logic [INDEX_W-1:0] index_reg;

    // result stage
    logic                     done_reg;
    logic                     known_reg;
    logic [ID_W-1:0]          id_reg;
    logic [FMT_W-1:0]         fmt_reg;
    logic [REG_W-1:0]         rd_reg;
    logic [REG_W-1:0]         rs_reg;
    logic [REG_W-1:0]         rt_reg;
    logic [REG_W-1:0]         sh_reg;
    logic signed [IMMX_W-1:0] imm_reg;
    logic [WORD_W-1:0]        target_reg;
    logic                     unk_reg;

    op_info_t                 info;
    logic [REG_W-1:0]         rd;
    logic [REG_W-1:0]         rs;
    logic [REG_W-1:0]         rt;
    logic [IMM_W-1:0]         imm16;
    logic                     is_andi;
    logic                     is_branch;
    logic signed [IMMX_W-1:0] imm_next;
    logic                     unk_next;
    logic [WORD_W-1:0]        target_next;

    assign busy = 1'b0;

    assign rd    = word_reg[15:11];
    assign rs    = word_reg[25:21];
    assign rt    = word_reg[20:16];
    assign imm16 = word_reg[IMM_W-1:0];

    mid_op_lookup u_lookup (
        .opcode (word_reg[WORD_W-1 -: OPC_W]),
        .funct  (word_reg[OPC_W-1:0]),
        .info   (info)
    );

    assign is_andi   = info.valid && (info.id == ID_ANDI);
    assign is_branch = info.valid && ((info.id == ID_BEQ) || (info.id == ID_BNE));
    assign imm_next  = is_andi ? {1'b0, imm16} : {imm16[IMM_W-1], imm16};

    mid_target_calc u_target (
        .word_index (index_reg),
        .imm        (imm16),
        .is_branch  (is_branch),
        .target     (target_next)
    );

    always_comb
    begin
        unk_next = 1'b0;
        if (info.valid)
        begin
            case (info.fmt)
                FMT_SHIFT: unk_next = (rd >= FIRST_BAD_REG) || (rt >= FIRST_BAD_REG);
                FMT_RRR:   unk_next = (rd >= FIRST_BAD_REG) || (rs >= FIRST_BAD_REG)
                                   || (rt >= FIRST_BAD_REG);
                FMT_RI:    unk_next = (rt >= FIRST_BAD_REG);
                default:   unk_next = (rs >= FIRST_BAD_REG) || (rt >= FIRST_BAD_REG);
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            in_valid_reg <= start && !busy;
            done_reg     <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            word_reg  <= instr_word;
            index_reg <= word_index;
        end
        if (in_valid_reg)
        begin
            known_reg  <= info.valid;
            id_reg     <= info.id;
            fmt_reg    <= info.fmt;
            rd_reg     <= rd;
            rs_reg     <= rs;
            rt_reg     <= rt;
            sh_reg     <= word_reg[10:6];
            imm_reg    <= imm_next;
            target_reg <= target_next;
            unk_reg    <= unk_next;
        end
    end

    assign done             = done_reg;
    assign known_op         = known_reg;
    assign mnemonic_id      = id_reg;
    assign operand_format   = fmt_reg;
    assign dest_reg         = rd_reg;
    assign src_reg          = rs_reg;
    assign second_reg       = rt_reg;
    assign shift_amount     = sh_reg;
    assign immediate_value  = imm_reg;
    assign branch_target    = target_reg;
    assign reg_name_unknown = unk_reg;

endmodule

[rtl/core/mid_checker.sv]
// ----------------------------------------------------------------------------
// mid_port_checks: port-level checks for the instruction decoder
// Timing of results and consistency of the decoded fields.
// ----------------------------------------------------------------------------
module mid_port_checks (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                done,
    input  logic                                known_op,
    input  logic [mid_pkg::ID_W-1:0]            mnemonic_id,
    input  logic [mid_pkg::FMT_W-1:0]           operand_format,
    input  logic signed [mid_pkg::IMMX_W-1:0]   immediate_value,
    input  logic [mid_pkg::WORD_W-1:0]          branch_target,
    input  logic                                reg_name_unknown
);
    import mid_pkg::*;

    // every accepted item yields its result with done after both registers
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result missing two cycles after accept");

    // unsupported words carry zero id, format, target and flag
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !known_op) |-> (mnemonic_id == ID_SLL) && (operand_format == FMT_SHIFT)
            && (branch_target == '0) && !reg_name_unknown)
        else $error("unsupported word with nonzero decode");

    // only branches carry a target
    a_target_branch: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (operand_format != FMT_BR)) |-> (branch_target == '0))
        else $error("target on a non-branch item");

    // target is a word address
    a_target_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (branch_target[1:0] == 2'b00))
        else $error("branch target not word aligned");

    // immediate is sign-extended except for andi
    a_imm_ext: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !(known_op && (mnemonic_id == ID_ANDI)))
            |-> (immediate_value[IMMX_W-1] == immediate_value[IMMX_W-2]))
        else $error("immediate not sign-extended");

endmodule

bind mips_instruction_decoder mid_port_checks u_mid_port_checks (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .known_op         (known_op),
    .mnemonic_id      (mnemonic_id),
    .operand_format   (operand_format),
    .immediate_value  (immediate_value),
    .branch_target    (branch_target),
    .reg_name_unknown (reg_name_unknown)
);

[tb/mid_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mid_checker: result checker for the MIPS instruction decoder
// Watches the command and result channels, predicts the decode of every
// accepted item and compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module mid_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  logic [mid_pkg::WORD_W-1:0]         instr_word,
    input  logic [mid_pkg::INDEX_W-1:0]        word_index,
    input  logic                               done,
    input  logic                               known_op,
    input  logic [mid_pkg::ID_W-1:0]           mnemonic_id,
    input  logic [mid_pkg::FMT_W-1:0]          operand_format,
    input  logic [mid_pkg::REG_W-1:0]          dest_reg,
    input  logic [mid_pkg::REG_W-1:0]          src_reg,
    input  logic [mid_pkg::REG_W-1:0]          second_reg,
    input  logic [mid_pkg::REG_W-1:0]          shift_amount,
    input  logic signed [mid_pkg::IMMX_W-1:0]  immediate_value,
    input  logic [mid_pkg::WORD_W-1:0]         branch_target,
    input  logic                               reg_name_unknown,
    output int                                 fail_count,
    output int                                 decodes_in_flight
);
    import mid_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] src_word;
        logic              known;
        logic [ID_W-1:0]   id;
        logic [FMT_W-1:0]  fmt;
        logic [REG_W-1:0]  rd;
        logic [REG_W-1:0]  rs;
        logic [REG_W-1:0]  rt;
        logic [REG_W-1:0]  sh;
        logic [IMMX_W-1:0] imm;
        logic [WORD_W-1:0] target;
        logic              unk;
    } decode_result_t;

    decode_result_t pending_decodes [$];
    decode_result_t want;
    decode_result_t got;
    int             mismatches = 0;
    int             in_flight = 0;

    assign fail_count        = mismatches;
    assign decodes_in_flight = in_flight;

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [WORD_W-1:0] seen,
                               input logic [WORD_W-1:0] wanted);
        if (seen !== wanted)
            report_mismatch($sformatf("word %h: %s got %h expected %h",
                                      want.src_word, name, seen, wanted));
    endtask

    function automatic op_info_t supported(input logic [ID_W-1:0] id,
                                           input logic [FMT_W-1:0] fmt);
        op_info_t op;
        op.valid = 1'b1;
        op.id    = id;
        op.fmt   = fmt;
        return op;
    endfunction

    function automatic decode_result_t predict_decode(input logic [WORD_W-1:0] word,
                                                      input logic [INDEX_W-1:0] idx);
        decode_result_t    r;
        op_info_t          op;
        logic [WORD_W-1:0] sum;
        r  = '0;
        op = '0;
        if (word[31:26] == OPC_RTYPE)
        begin
            case (word[5:0])
                FN_SLL:  op = supported(ID_SLL, FMT_SHIFT);
                FN_SRL:  op = supported(ID_SRL, FMT_SHIFT);
                FN_ADD:  op = supported(ID_ADD, FMT_RRR);
                FN_ADDU: op = supported(ID_ADDU, FMT_RRR);
                FN_SUB:  op = supported(ID_SUB, FMT_RRR);
                FN_SUBU: op = supported(ID_SUBU, FMT_RRR);
                FN_AND:  op = supported(ID_AND, FMT_RRR);
                FN_OR:   op = supported(ID_OR, FMT_RRR);
                FN_NOR:  op = supported(ID_NOR, FMT_RRR);
                FN_SLT:  op = supported(ID_SLT, FMT_RRR);
                FN_SLTU: op = supported(ID_SLTU, FMT_RRR);
                default: op = '0;
            endcase
        end
        else
        begin
            case (word[31:26])
                OPC_BEQ:   op = supported(ID_BEQ, FMT_BR);
                OPC_BNE:   op = supported(ID_BNE, FMT_BR);
                OPC_ADDI:  op = supported(ID_ADDI, FMT_RRI);
                OPC_ADDIU: op = supported(ID_ADDIU, FMT_RRI);
                OPC_SLTI:  op = supported(ID_SLTI, FMT_RRI);
                OPC_SLTIU: op = supported(ID_SLTIU, FMT_RRI);
                OPC_ANDI:  op = supported(ID_ANDI, FMT_RRI);
                OPC_ORI:   op = supported(ID_ORI, FMT_RRI);
                OPC_LUI:   op = supported(ID_LUI, FMT_RI);
                OPC_LW:    op = supported(ID_LW, FMT_MEM);
                OPC_LBU:   op = supported(ID_LBU, FMT_MEM);
                OPC_LHU:   op = supported(ID_LHU, FMT_MEM);
                OPC_SB:    op = supported(ID_SB, FMT_MEM);
                OPC_SH:    op = supported(ID_SH, FMT_MEM);
                OPC_SW:    op = supported(ID_SW, FMT_MEM);
                OPC_LL:    op = supported(ID_LL, FMT_MEM);
                OPC_SC:    op = supported(ID_SC, FMT_MEM);
                default:   op = '0;
            endcase
        end

        r.src_word = word;
        r.known    = op.valid;
        r.id       = op.id;
        r.fmt      = op.fmt;
        r.rd       = word[15:11];
        r.rs       = word[25:21];
        r.rt       = word[20:16];
        r.sh       = word[10:6];
        // only andi zero-extends; unsupported words sign-extend too
        r.imm = (op.valid && op.id == ID_ANDI) ? {1'b0, word[15:0]}
                                               : {word[15], word[15:0]};
        if (op.valid)
        begin
            case (op.fmt)
                FMT_SHIFT: r.unk = (r.rd >= FIRST_BAD_REG) || (r.rt >= FIRST_BAD_REG);
                FMT_RRR:   r.unk = (r.rd >= FIRST_BAD_REG) || (r.rs >= FIRST_BAD_REG)
                                   || (r.rt >= FIRST_BAD_REG);
                FMT_RI:    r.unk = (r.rt >= FIRST_BAD_REG);
                default:   r.unk = (r.rs >= FIRST_BAD_REG) || (r.rt >= FIRST_BAD_REG);
            endcase
            if (op.id == ID_BEQ || op.id == ID_BNE)
            begin
                sum      = WORD_W'(idx) + 32'd1 + {{15{r.imm[IMMX_W-1]}}, r.imm};
                r.target = sum << 2;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_decodes.delete();
            in_flight <= 0;
        end
        else
        begin
            // retire first: a result at this edge belongs to an older item
            if (done)
            begin
                if (pending_decodes.size() == 0)
                begin
                    report_mismatch($sformatf("result with no item pending, mnemonic %0d",
                                              mnemonic_id));
                end
                else
                begin
                    want       = pending_decodes.pop_front();
                    got        = want;
                    got.known  = known_op;
                    got.id     = mnemonic_id;
                    got.fmt    = operand_format;
                    got.rd     = dest_reg;
                    got.rs     = src_reg;
                    got.rt     = second_reg;
                    got.sh     = shift_amount;
                    got.imm    = immediate_value;
                    got.target = branch_target;
                    got.unk    = reg_name_unknown;
                    check_field("known_op", WORD_W'(got.known), WORD_W'(want.known));
                    check_field("mnemonic_id", WORD_W'(got.id), WORD_W'(want.id));
                    check_field("operand_format", WORD_W'(got.fmt), WORD_W'(want.fmt));
                    check_field("dest_reg", WORD_W'(got.rd), WORD_W'(want.rd));
                    check_field("src_reg", WORD_W'(got.rs), WORD_W'(want.rs));
                    check_field("second_reg", WORD_W'(got.rt), WORD_W'(want.rt));
                    check_field("shift_amount", WORD_W'(got.sh), WORD_W'(want.sh));
                    check_field("immediate_value", WORD_W'(got.imm), WORD_W'(want.imm));
                    check_field("branch_target", got.target, want.target);
                    check_field("reg_name_unknown", WORD_W'(got.unk), WORD_W'(want.unk));
                end
            end
            if (start && !busy)
                pending_decodes.insert(pending_decodes.size(),
                                       predict_decode(instr_word, word_index));
            in_flight <= pending_decodes.size();
        end
    end

endmodule

[tb/tb_mips_instruction_decoder.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mips_instruction_decoder: testbench for the MIPS instruction decoder
// Drives directed and random instruction words with random gaps; the
// checker predicts every decode and reports mismatches.
// ----------------------------------------------------------------------------
module tb_mips_instruction_decoder;
    import mid_pkg::*;

    localparam int RANDOM_ITEMS = 850;
    localparam int LIMIT_CYCLES = 200000;
    localparam int TAIL_CYCLES  = 6;

    // codes that no supported operation uses
    localparam logic [OPC_W-1:0] OPC_UNUSED = 6'd63;
    localparam logic [OPC_W-1:0] FN_UNUSED  = 6'd1;

    localparam logic [10:0][OPC_W-1:0] RTYPE_FUNCTS = {
        FN_SLTU, FN_SLT, FN_NOR, FN_OR, FN_AND, FN_SUBU,
        FN_SUB, FN_ADDU, FN_ADD, FN_SRL, FN_SLL
    };
    localparam logic [16:0][OPC_W-1:0] ITYPE_OPCODES = {
        OPC_SC, OPC_LL, OPC_SW, OPC_SH, OPC_SB, OPC_LHU, OPC_LBU, OPC_LW,
        OPC_LUI, OPC_ORI, OPC_ANDI, OPC_SLTIU, OPC_SLTI, OPC_ADDIU, OPC_ADDI,
        OPC_BNE, OPC_BEQ
    };

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [WORD_W-1:0]         instr_word;
    logic [INDEX_W-1:0]        word_index;
    logic                      done;
    logic                      known_op;
    logic [ID_W-1:0]           mnemonic_id;
    logic [FMT_W-1:0]          operand_format;
    logic [REG_W-1:0]          dest_reg;
    logic [REG_W-1:0]          src_reg;
    logic [REG_W-1:0]          second_reg;
    logic [REG_W-1:0]          shift_amount;
    logic signed [IMMX_W-1:0]  immediate_value;
    logic [WORD_W-1:0]         branch_target;
    logic                      reg_name_unknown;
    int                        fail_count;
    int                        decodes_in_flight;
    int                        cycle_count = 0;
    bit                        idle_on;

    mips_instruction_decoder u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .instr_word       (instr_word),
        .word_index       (word_index),
        .done             (done),
        .known_op         (known_op),
        .mnemonic_id      (mnemonic_id),
        .operand_format   (operand_format),
        .dest_reg         (dest_reg),
        .src_reg          (src_reg),
        .second_reg       (second_reg),
        .shift_amount     (shift_amount),
        .immediate_value  (immediate_value),
        .branch_target    (branch_target),
        .reg_name_unknown (reg_name_unknown)
    );

    mid_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .instr_word        (instr_word),
        .word_index        (word_index),
        .done              (done),
        .known_op          (known_op),
        .mnemonic_id       (mnemonic_id),
        .operand_format    (operand_format),
        .dest_reg          (dest_reg),
        .src_reg           (src_reg),
        .second_reg        (second_reg),
        .shift_amount      (shift_amount),
        .immediate_value   (immediate_value),
        .branch_target     (branch_target),
        .reg_name_unknown  (reg_name_unknown),
        .fail_count        (fail_count),
        .decodes_in_flight (decodes_in_flight)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic logic [WORD_W-1:0] r_word(input logic [OPC_W-1:0] fn,
                                                 input logic [REG_W-1:0] rs,
                                                 input logic [REG_W-1:0] rt,
                                                 input logic [REG_W-1:0] rd,
                                                 input logic [REG_W-1:0] sh);
        return {OPC_RTYPE, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [WORD_W-1:0] i_word(input logic [OPC_W-1:0] opc,
                                                 input logic [REG_W-1:0] rs,
                                                 input logic [REG_W-1:0] rt,
                                                 input logic [IMM_W-1:0] imm);
        return {opc, rs, rt, imm};
    endfunction

    function automatic logic [REG_W-1:0] rand_reg();
        return REG_W'($urandom_range(0, 31));
    endfunction

    function automatic logic [IMM_W-1:0] rand_imm();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h7FFF;
            default: return IMM_W'($urandom);
        endcase
    endfunction

    function automatic logic [INDEX_W-1:0] rand_index();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return INDEX_W'($urandom);
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] supported_word(input int k);
        if (k < 11)
            return r_word(RTYPE_FUNCTS[k], rand_reg(), rand_reg(), rand_reg(), rand_reg());
        return i_word(ITYPE_OPCODES[k-11], rand_reg(), rand_reg(), rand_imm());
    endfunction

    // holds start high across back-to-back items; drops it only for a gap
    task automatic send_item(input logic [WORD_W-1:0] w, input logic [INDEX_W-1:0] idx);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        instr_word <= w;
        word_index <= idx;
        do @(posedge clk); while (busy);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        @(posedge clk);
        while (decodes_in_flight != 0) @(posedge clk);
    endtask

    initial
    begin
        int k;
        start      = 1'b0;
        instr_word = '0;
        word_index = '0;
        rst_n      = 1'b0;
        idle_on    = 1'b1;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // every operation once
        for (k = 0; k < 28; k++)
            send_item(supported_word(k), rand_index());

        // field extremes and corner cases
        send_item('0, '0);
        send_item('1, '1);
        send_item(r_word(FN_UNUSED, 5'd31, 5'd31, 5'd31, 5'd31), rand_index());
        send_item(i_word(OPC_UNUSED, 5'd0, 5'd0, 16'h8000), rand_index());
        send_item(i_word(OPC_ANDI, 5'd0, 5'd0, 16'hFFFF), rand_index());
        send_item(i_word(OPC_ANDI, 5'd25, 5'd26, 16'h8000), rand_index());
        send_item(i_word(OPC_ORI, 5'd1, 5'd2, 16'h8000), rand_index());
        send_item(i_word(OPC_LUI, 5'd31, 5'd25, 16'hFFFF), rand_index());
        // branch targets wrapping past the top and below zero
        send_item(i_word(OPC_BEQ, 5'd3, 5'd4, 16'hFFFF), '1);
        send_item(i_word(OPC_BNE, 5'd25, 5'd25, 16'h7FFF), '1);
        send_item(i_word(OPC_BEQ, 5'd26, 5'd0, 16'h8000), '0);
        // register flag only looks at the fields the format uses
        send_item(r_word(FN_SLL, 5'd31, 5'd0, 5'd0, 5'd31), rand_index());
        send_item(r_word(FN_SRL, 5'd0, 5'd26, 5'd0, 5'd1), rand_index());
        send_item(r_word(FN_ADD, 5'd25, 5'd25, 5'd26, 5'd31), rand_index());
        send_item(r_word(FN_ADDU, 5'd25, 5'd25, 5'd25, 5'd0), rand_index());
        send_item(i_word(OPC_LW, 5'd26, 5'd0, 16'h0004), rand_index());
        send_item({OPC_SW, 5'd0, 5'd0, 5'd31, 11'd0}, rand_index());
        drain_results();

        for (k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 100 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if (k == RANDOM_ITEMS / 2)
                drain_results();
            case ($urandom_range(0, 19))
                0, 1, 2:  send_item($urandom, rand_index());
                3, 4:     send_item(r_word(OPC_W'($urandom), rand_reg(), rand_reg(),
                                           rand_reg(), rand_reg()), rand_index());
                default:  send_item(supported_word($urandom_range(0, 27)), rand_index());
            endcase
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && decodes_in_flight == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
